FILE: hdl/hsdp_pkg.sv
// Package for the half/single dot product unit: floating-point helper functions.
// No dependencies.
`default_nettype none
package hsdp_pkg;

	localparam logic [31:0] QNAN32 = 32'h7FC00000;

	// Shift right, keeping a sticky bit in the lowest position.
	function automatic logic [31:0] jam_right(input logic [31:0] a, input logic [8:0] cnt);
		logic [31:0] r;
		logic [31:0] lost;
		begin
			if (cnt == 9'd0) begin
				r = a;
			end else if (cnt < 9'd32) begin
				lost = a << (6'd32 - {1'b0, cnt[4:0]});
				r = (a >> cnt[4:0]) | {31'd0, lost != 32'd0};
			end else begin
				r = {31'd0, a != 32'd0};
			end
			return r;
		end
	endfunction

	// Leading zero count of a 32-bit word.
	function automatic logic [5:0] lead_zeros(input logic [31:0] a);
		logic [5:0] n;
		logic found;
		begin
			n = 6'd32;
			found = 1'b0;
			for (int i = 31; i >= 0; i--) begin
				if (a[i] && !found) begin
					n = 6'(31 - i);
					found = 1'b1;
				end
			end
			return n;
		end
	endfunction

	// Rounds to nearest even; exp is the biased exponent minus one, lead bit at bit 30.
	function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] exp_in,
		input logic [31:0] sig_in);
		logic [31:0] sig;
		logic signed [10:0] ex;
		logic [6:0] rbits;
		logic [32:0] sum;
		logic [31:0] r;
		begin
			sig = sig_in;
			ex = exp_in;
			rbits = sig[6:0];
			if (ex > 11'sd253 || (ex == 11'sd253 && ({1'b0, sig} + 33'h40) >= 33'h80000000)) begin
				r = {sign, 31'h7F800000};
			end else begin
				if (ex < 0) begin
					sig = jam_right(sig, 9'((-ex) > 11'sd255 ? 11'sd255 : -ex));
					ex = 11'sd0;
					rbits = sig[6:0];
				end
				sum = ({1'b0, sig} + 33'h40) >> 7;
				if (rbits == 7'h40) sum[0] = 1'b0;
				if (sum == 33'd0) ex = 11'sd0;
				r = {sign, 31'd0} + {1'b0, ex[7:0], 23'd0} + sum[31:0];
			end
			return r;
		end
	endfunction

	// Exact widening of binary16 to binary32.
	function automatic logic [31:0] widen_half(input logic [15:0] h);
		logic [3:0] lz;
		logic [10:0] m;
		logic [31:0] r;
		begin
			lz = 4'd0;
			m = {1'b0, h[9:0]};
			if (h[14:10] == 5'd0) begin
				if (h[9:0] == 10'd0) begin
					r = {h[15], 31'd0};
				end else begin
					lz = 4'(lead_zeros({22'd0, h[9:0]}) - 6'd21);
					m = m << lz;
					r = {h[15], 8'(8'd113 - {4'd0, lz}), m[9:0], 13'd0};
				end
			end else if (h[14:10] == 5'h1F) begin
				r = (h[9:0] == 10'd0) ? {h[15], 31'h7F800000} : QNAN32;
			end else begin
				r = {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
			end
			return r;
		end
	endfunction

endpackage
`default_nettype wire

FILE: hdl/half_single_dot_product_unit.sv
// Top level of the half/single dot product unit: multiply stage and accumulate stage.
// Depends on hsdp_pkg.
// Path from input transaction to result: input register, product register, then accumulator and result register.
// Throughput: one item per cycle unless a result waits in the output register; the accumulator loop is one adder wide.
// Reset clears the accumulator to +0 and drops all pending items and results.
`default_nettype none
module half_single_dot_product_unit import hsdp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // single_value[31:0], half_weight[47:32]
	input  wire logic        s_tlast,  // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // dot_sum
);

	logic        v_s1, last_s1;
	logic [31:0] a_s1, b_s1;
	logic [31:0] prod_s2;
	logic        v_s2, last_s2;
	logic [31:0] acc_q;
	logic [31:0] prod, sum, out_q;
	logic        out_v_q;
	logic        adv;

	// Multiply for binary32 with one rounding.
	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic sgn;
		logic signed [10:0] ae, be, ze;
		logic [22:0] as0, bs0;
		logic [31:0] as, bs, zs;
		logic [47:0] pm;
		logic [63:0] p;
		logic [5:0] sh;
		logic [31:0] r;
		begin
			sgn = a[31] ^ b[31];
			ae = {3'd0, a[30:23]};
			be = {3'd0, b[30:23]};
			as0 = a[22:0];
			bs0 = b[22:0];
			as = {9'd0, as0};
			bs = {9'd0, bs0};
			pm = 48'd0;
			p = 64'd0;
			if ((ae == 11'sd255 && as0 != 0) || (be == 11'sd255 && bs0 != 0)) begin
				r = QNAN32;
			end else if (ae == 11'sd255) begin
				r = (be == 0 && bs0 == 0) ? QNAN32 : {sgn, 31'h7F800000};
			end else if (be == 11'sd255) begin
				r = (ae == 0 && as0 == 0) ? QNAN32 : {sgn, 31'h7F800000};
			end else if ((ae == 0 && as0 == 0) || (be == 0 && bs0 == 0)) begin
				r = {sgn, 31'd0};
			end else begin
				if (ae == 0) begin
					sh = lead_zeros(as) - 6'd8;
					as = as << sh;
					ae = 11'sd1 - $signed({5'd0, sh});
				end
				if (be == 0) begin
					sh = lead_zeros(bs) - 6'd8;
					bs = bs << sh;
					be = 11'sd1 - $signed({5'd0, sh});
				end
				ze = ae + be - 11'sd127;
				as = as | 32'h800000;
				bs = bs | 32'h800000;
				// 24 by 24 significand product, aligned as if the operands sat at bits 30 and 31.
				pm = as[23:0] * bs[23:0];
				p = {1'b0, pm, 15'd0};
				zs = p[63:32] | {31'd0, p[31:0] != 32'd0};
				if (!zs[30]) begin
					zs = zs << 1;
					ze = ze - 11'sd1;
				end
				r = round_pack(sgn, ze, zs);
			end
			return r;
		end
	endfunction

	// Add for binary32 with one rounding.
	function automatic logic [31:0] add32(input logic [31:0] a, input logic [31:0] b);
		logic sa, sb, t;
		logic signed [10:0] ea, eb, te, ze;
		logic [31:0] ma, mb, tm, z, r;
		logic [5:0] sh;
		begin
			sa = a[31];
			sb = b[31];
			ea = {3'd0, a[30:23]};
			eb = {3'd0, b[30:23]};
			ma = {9'd0, a[22:0]};
			mb = {9'd0, b[22:0]};
			if ((ea == 11'sd255 && ma != 0) || (eb == 11'sd255 && mb != 0)) begin
				r = QNAN32;
			end else if (ea == 11'sd255) begin
				r = (eb == 11'sd255 && sa != sb) ? QNAN32 : a;
			end else if (eb == 11'sd255) begin
				r = b;
			end else if (a[30:0] == 0 && b[30:0] == 0) begin
				r = {sa & sb, 31'd0};
			end else if (a[30:0] == 0) begin
				r = b;
			end else if (b[30:0] == 0) begin
				r = a;
			end else begin
				if (ea == 0) ea = 11'sd1; else ma = ma | 32'h800000;
				if (eb == 0) eb = 11'sd1; else mb = mb | 32'h800000;
				ma = ma << 7;
				mb = mb << 7;
				if (eb > ea || (eb == ea && mb > ma)) begin
					te = ea; ea = eb; eb = te;
					tm = ma; ma = mb; mb = tm;
					t = sa; sa = sb; sb = t;
				end
				mb = jam_right(mb, 9'(ea - eb));
				z = (sa == sb) ? ma + mb : ma - mb;
				if (sa != sb && z == 0) begin
					r = 32'd0;
				end else begin
					ze = ea - 11'sd1;
					if (z[31]) begin
						z = jam_right(z, 9'd1);
						ze = ea;
					end else begin
						sh = lead_zeros(z) - 6'd1;
						z = z << sh;
						ze = ze - $signed({5'd0, sh});
					end
					r = round_pack(sa, ze, z);
				end
			end
			return r;
		end
	endfunction

	// The pipeline stalls only when a result waits in the output register.
	assign adv = !(out_v_q && !m_tready);
	assign s_tready = adv;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	assign prod = mul32(a_s1, widen_half(b_s1[15:0]));
	assign sum = add32(acc_q, prod_s2);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= s_tdata[31:0];
			b_s1 <= {16'd0, s_tdata[47:32]};
			last_s1 <= s_tlast;
		end
	end

	// Product register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= prod;
			last_s2 <= last_s1;
		end
	end

	// Accumulator and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'd0;
			out_v_q <= 1'b0;
			out_q <= 32'd0;
		end else begin
			if (m_tready) out_v_q <= 1'b0;
			if (adv && v_s2) begin
				if (last_s2) begin
					acc_q <= 32'd0;
					out_v_q <= 1'b1;
					out_q <= (sum[30:23] == 8'hFF && sum[22:0] != 0) ? QNAN32 : sum;
				end else begin
					acc_q <= sum;
				end
			end
		end
	end

endmodule
`default_nettype wire
